// ===== rtl/core/rcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcmc_pkg
// Types, constants and helpers shared by the ROI mean color classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rcmc_pkg;

   localparam int MAX_LINE_WIDTH = 1024;
   localparam int MAX_ROWS       = 1024;

   localparam int COL_W   = $clog2(MAX_LINE_WIDTH);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int WIN_W   = 10;
   localparam int LINE_W  = 11;
   localparam int LEVEL_W = 5;
   localparam int CNT_W   = 20;
   localparam int SUM_W   = 25;
   localparam int QUO_W   = 5;
   localparam int STEP_W  = $clog2(QUO_W);
   localparam int WIDE_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int CMP_W   = ((WIDE_W > LINE_W) ? WIDE_W : LINE_W) + 1;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 11;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_FIRST   = 4'd0,
      REG_ROW_LAST    = 4'd1,
      REG_COL_FIRST   = 4'd2,
      REG_COL_LAST    = 4'd3,
      REG_LINE_WIDTH  = 4'd4,
      REG_RED_THRESH  = 4'd5,
      REG_GREEN_THRESH = 4'd6,
      REG_RED_FLOOR   = 4'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_RED   = 2'd1,
      CLASS_GREEN = 2'd2
   } color_class_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_DONE
   } bk_state_type;

   typedef struct packed {
      logic [WIN_W-1:0]   row_first;
      logic [WIN_W-1:0]   row_last;
      logic [WIN_W-1:0]   col_first;
      logic [WIN_W-1:0]   col_last;
      logic [LINE_W-1:0]  line_width;
      logic [LEVEL_W-1:0] red_threshold;
      logic [LEVEL_W-1:0] green_threshold;
      logic [LEVEL_W-1:0] red_floor;
   } cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0] red_sum;
      logic [SUM_W-1:0] green_sum;
      logic [CNT_W-1:0] pixels;
   } frame_type;

   function automatic color_class_type classify(input logic [QUO_W-1:0] avg_r,
                                                input logic [QUO_W-1:0] avg_g,
                                                input cfg_type cfg);
      color_class_type cls;
      cls = CLASS_NONE;
      if (avg_r > cfg.red_threshold) begin
         cls = CLASS_RED;
      end else if (avg_g > cfg.green_threshold && avg_r > cfg.red_floor &&
                   avg_g > avg_r) begin
         cls = CLASS_GREEN;
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rcmc_if.sv =====
// ----------------------------------------------------------------------------
// rcmc channel interfaces
// Pixel request, result response and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcmc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel;
   logic        last_in_frame;
   modport source (output valid, output pixel, output last_in_frame, input ready);
   modport sink   (input valid, input pixel, input last_in_frame, output ready);
endinterface

interface rcmc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rcmc_pkg::QUO_W-1:0]   average_red;
   logic [rcmc_pkg::QUO_W-1:0]   average_green;
   logic [1:0]                   color_class;
   modport source (output valid, output average_red, output average_green,
                   output color_class, input ready);
   modport sink   (input valid, input average_red, input average_green,
                   input color_class, output ready);
endinterface

interface rcmc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rcmc_pkg::CSR_IDX_W-1:0]    index;
   logic [rcmc_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rcmc_front.sv =====
// ----------------------------------------------------------------------------
// rcmc_front
// Register file, raster position tracking and window accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   rcmc_req_if.sink                 req,
   rcmc_csr_if.sink                 csr,
   input  wire logic                q_full,
   output logic                     q_push,
   output rcmc_pkg::frame_type      q_data,
   output rcmc_pkg::cfg_type        cfg
);

   rcmc_pkg::cfg_type                cfg_ff, cfg_in;
   logic [rcmc_pkg::COL_W-1:0]       col_ff, col_in;
   logic [rcmc_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [rcmc_pkg::SUM_W-1:0]       red_ff, red_in, red_add;
   logic [rcmc_pkg::SUM_W-1:0]       green_ff, green_in, green_add;
   logic [rcmc_pkg::CNT_W-1:0]       cnt_ff, cnt_in, cnt_add;
   logic [rcmc_pkg::CMP_W-1:0]       eff_width;
   logic [rcmc_pkg::CMP_W-1:0]       row_w, col_w;
   logic                             in_win;
   logic                             accept;

   assign cfg       = cfg_ff;
   assign csr.ready = 1'b1;
   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            rcmc_pkg::REG_ROW_FIRST:    cfg_in.row_first  = csr.data[rcmc_pkg::WIN_W-1:0];
            rcmc_pkg::REG_ROW_LAST:     cfg_in.row_last   = csr.data[rcmc_pkg::WIN_W-1:0];
            rcmc_pkg::REG_COL_FIRST:    cfg_in.col_first  = csr.data[rcmc_pkg::WIN_W-1:0];
            rcmc_pkg::REG_COL_LAST:     cfg_in.col_last   = csr.data[rcmc_pkg::WIN_W-1:0];
            rcmc_pkg::REG_LINE_WIDTH:   cfg_in.line_width = csr.data[rcmc_pkg::LINE_W-1:0];
            rcmc_pkg::REG_RED_THRESH:
               cfg_in.red_threshold = csr.data[rcmc_pkg::LEVEL_W-1:0];
            rcmc_pkg::REG_GREEN_THRESH:
               cfg_in.green_threshold = csr.data[rcmc_pkg::LEVEL_W-1:0];
            rcmc_pkg::REG_RED_FLOOR:
               cfg_in.red_floor = csr.data[rcmc_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      row_w = rcmc_pkg::CMP_W'(row_ff);
      col_w = rcmc_pkg::CMP_W'(col_ff);

      if (cfg_ff.line_width == '0) begin
         eff_width = rcmc_pkg::CMP_W'(1);
      end else if (rcmc_pkg::CMP_W'(cfg_ff.line_width) >
                   rcmc_pkg::CMP_W'(rcmc_pkg::MAX_LINE_WIDTH)) begin
         eff_width = rcmc_pkg::CMP_W'(rcmc_pkg::MAX_LINE_WIDTH);
      end else begin
         eff_width = rcmc_pkg::CMP_W'(cfg_ff.line_width);
      end

      in_win = row_w >= rcmc_pkg::CMP_W'(cfg_ff.row_first) &&
               row_w <= rcmc_pkg::CMP_W'(cfg_ff.row_last) &&
               col_w >= rcmc_pkg::CMP_W'(cfg_ff.col_first) &&
               col_w <= rcmc_pkg::CMP_W'(cfg_ff.col_last) &&
               cnt_ff != rcmc_pkg::CNT_MAX;

      red_add   = red_ff;
      green_add = green_ff;
      cnt_add   = cnt_ff;
      if (in_win) begin
         red_add   = red_ff + rcmc_pkg::SUM_W'(req.pixel[15:11]);
         green_add = green_ff + rcmc_pkg::SUM_W'(req.pixel[10:6]);
         cnt_add   = cnt_ff + rcmc_pkg::CNT_W'(1);
      end

      q_data.red_sum   = red_add;
      q_data.green_sum = green_add;
      q_data.pixels    = cnt_add;
      q_push           = accept && req.last_in_frame;

      col_in   = col_ff;
      row_in   = row_ff;
      red_in   = red_ff;
      green_in = green_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         if (req.last_in_frame) begin
            col_in   = '0;
            row_in   = '0;
            red_in   = '0;
            green_in = '0;
            cnt_in   = '0;
         end else begin
            red_in   = red_add;
            green_in = green_add;
            cnt_in   = cnt_add;
            if (col_w + rcmc_pkg::CMP_W'(1) >= eff_width) begin
               col_in = '0;
               if (row_w + rcmc_pkg::CMP_W'(1) >= rcmc_pkg::CMP_W'(rcmc_pkg::MAX_ROWS)) begin
                  row_in = '0;
               end else begin
                  row_in = row_ff + rcmc_pkg::ROW_W'(1);
               end
            end else begin
               col_in = col_ff + rcmc_pkg::COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_first       <= rcmc_pkg::WIN_W'(187);
         cfg_ff.row_last        <= rcmc_pkg::WIN_W'(233);
         cfg_ff.col_first       <= rcmc_pkg::WIN_W'(154);
         cfg_ff.col_last        <= rcmc_pkg::WIN_W'(186);
         cfg_ff.line_width      <= rcmc_pkg::LINE_W'(320);
         cfg_ff.red_threshold   <= rcmc_pkg::LEVEL_W'(30);
         cfg_ff.green_threshold <= rcmc_pkg::LEVEL_W'(20);
         cfg_ff.red_floor       <= rcmc_pkg::LEVEL_W'(10);
         col_ff   <= '0;
         row_ff   <= '0;
         red_ff   <= '0;
         green_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rcmc_queue.sv =====
// ----------------------------------------------------------------------------
// rcmc_queue
// Short FIFO of finished frame totals between accumulator and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire rcmc_pkg::frame_type   push_data,
   input  wire logic                  pop,
   output rcmc_pkg::frame_type        pop_data,
   output logic                       full,
   output logic                       empty
);

   rcmc_pkg::frame_type               mem_ff [rcmc_pkg::QUEUE_DEPTH];
   logic [rcmc_pkg::QPTR_W-1:0]       wr_ff, wr_in;
   logic [rcmc_pkg::QPTR_W-1:0]       rd_ff, rd_in;
   logic [rcmc_pkg::QPTR_W:0]         fill_ff, fill_in;

   assign full     = fill_ff == (rcmc_pkg::QPTR_W+1)'(rcmc_pkg::QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == rcmc_pkg::QPTR_W'(rcmc_pkg::QUEUE_DEPTH-1)) ? '0 :
                 wr_ff + rcmc_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == rcmc_pkg::QPTR_W'(rcmc_pkg::QUEUE_DEPTH-1)) ? '0 :
                 rd_ff + rcmc_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + (rcmc_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (rcmc_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rcmc_back.sv =====
// ----------------------------------------------------------------------------
// rcmc_back
// Bit-serial mean divider, color classification and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  wire rcmc_pkg::frame_type   q_data,
   output logic                       q_pop,
   input  wire rcmc_pkg::cfg_type     cfg,
   rcmc_rsp_if.source                 rsp
);

   rcmc_pkg::bk_state_type            state_ff, state_in;
   logic [rcmc_pkg::SUM_W-1:0]        rem_r_ff, rem_r_in;
   logic [rcmc_pkg::SUM_W-1:0]        rem_g_ff, rem_g_in;
   logic [rcmc_pkg::CNT_W-1:0]        div_ff, div_in;
   logic [rcmc_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [rcmc_pkg::QUO_W-1:0]        quo_r_ff, quo_r_in;
   logic [rcmc_pkg::QUO_W-1:0]        quo_g_ff, quo_g_in;
   logic                              valid_ff, valid_in;
   logic [rcmc_pkg::QUO_W-1:0]        avg_r_ff, avg_r_in;
   logic [rcmc_pkg::QUO_W-1:0]        avg_g_ff, avg_g_in;
   rcmc_pkg::color_class_type         cls_ff, cls_in;
   logic [rcmc_pkg::SUM_W-1:0]        trial;
   logic                              out_free;

   assign rsp.valid         = valid_ff;
   assign rsp.average_red   = avg_r_ff;
   assign rsp.average_green = avg_g_ff;
   assign rsp.color_class   = cls_ff;
   assign out_free          = !valid_ff || rsp.ready;
   assign trial             = rcmc_pkg::SUM_W'(div_ff) << step_ff;

   always_comb begin
      state_in = state_ff;
      rem_r_in = rem_r_ff;
      rem_g_in = rem_g_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      quo_r_in = quo_r_ff;
      quo_g_in = quo_g_ff;
      avg_r_in = avg_r_ff;
      avg_g_in = avg_g_ff;
      cls_in   = cls_ff;
      valid_in = valid_ff && !rsp.ready;
      q_pop    = 1'b0;

      case (state_ff)
         rcmc_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               rem_r_in = q_data.red_sum;
               rem_g_in = q_data.green_sum;
               div_in   = q_data.pixels;
               step_in  = rcmc_pkg::STEP_W'(rcmc_pkg::QUO_W-1);
               quo_r_in = '0;
               quo_g_in = '0;
               state_in = rcmc_pkg::BK_DIVIDE;
            end
         end
         rcmc_pkg::BK_DIVIDE: begin
            if (rem_r_ff >= trial) begin
               rem_r_in          = rem_r_ff - trial;
               quo_r_in[step_ff] = 1'b1;
            end
            if (rem_g_ff >= trial) begin
               rem_g_in          = rem_g_ff - trial;
               quo_g_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) begin
               state_in = rcmc_pkg::BK_DONE;
            end else begin
               step_in = step_ff - rcmc_pkg::STEP_W'(1);
            end
         end
         rcmc_pkg::BK_DONE: begin
            if (out_free) begin
               valid_in = 1'b1;
               // empty window: divider result is meaningless
               if (div_ff == '0) begin
                  avg_r_in = '0;
                  avg_g_in = '0;
                  cls_in   = rcmc_pkg::CLASS_NONE;
               end else begin
                  avg_r_in = quo_r_ff;
                  avg_g_in = quo_g_ff;
                  cls_in   = rcmc_pkg::classify(quo_r_ff, quo_g_ff, cfg);
               end
               state_in = rcmc_pkg::BK_IDLE;
            end
         end
         default: state_in = rcmc_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_r_ff <= rem_r_in;
      rem_g_ff <= rem_g_in;
      div_ff   <= div_in;
      step_ff  <= step_in;
      quo_r_ff <= quo_r_in;
      quo_g_ff <= quo_g_in;
      avg_r_ff <= avg_r_in;
      avg_g_ff <= avg_g_in;
      cls_ff   <= cls_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcmc_pkg::BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/roi_color_mean_classifier.sv =====
// ----------------------------------------------------------------------------
// roi_color_mean_classifier
// Mean red/green over a rectangular window of an RGB565 frame, with class.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : one RGB565 pixel per beat in raster order; last_in_frame marks
//             the final pixel. Row and column are counted internally.
//   rsp_ch  : one beat per frame with average_red, average_green, color_class.
//   csr_ch  : register writes (index, data), always ready; write only while
//             no frame result is outstanding.
// Throughput: one pixel per cycle. Pixels stall only while two frame totals
//   are queued ahead of the divider.
// Result path: the last pixel beat pushes its totals into the queue, then
//   queue pop, 5 divide steps of the shared bit-serial divider, result load.
//   The divider takes a new frame only after the last result is loaded.
// Reset: registers take their default window and thresholds, counters and
//   sums clear, no result pending.
// A stalled response holds in the result register; the divider waits behind
//   it and the totals queue absorbs up to two more frames.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_color_mean_classifier (
   input  wire logic    clock,
   input  wire logic    reset,
   rcmc_req_if.sink     req_ch,
   rcmc_rsp_if.source   rsp_ch,
   rcmc_csr_if.sink     csr_ch
);

   rcmc_pkg::frame_type push_data;
   rcmc_pkg::frame_type pop_data;
   rcmc_pkg::cfg_type   cfg;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;

   rcmc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .csr    (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (push_data),
      .cfg    (cfg)
   );

   rcmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   rcmc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (pop_data),
      .q_pop   (q_pop),
      .cfg     (cfg),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== rtl/core/rcmc_checker.sv =====
// ----------------------------------------------------------------------------
// rcmc_checker
// Port-level checks on the result channel of the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [rcmc_pkg::QUO_W-1:0]    rsp_average_red,
   input wire logic [rcmc_pkg::QUO_W-1:0]    rsp_average_green,
   input wire logic [1:0]                    rsp_color_class
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_average_red) &&
         $stable(rsp_average_green) && $stable(rsp_color_class))
      else $error("result payload changed while stalled");

   a_class_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_color_class != 2'd3)
      else $error("undefined color class");

   a_green_wins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_color_class == rcmc_pkg::CLASS_GREEN |->
         rsp_average_green > rsp_average_red)
      else $error("green class without green above red");

endmodule

bind roi_color_mean_classifier rcmc_checker u_rcmc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_average_red   (rsp_ch.average_red),
   .rsp_average_green (rsp_ch.average_green),
   .rsp_color_class   (rsp_ch.color_class)
);

`default_nettype wire
